// ----- hw/rtl/slsel_pkg.sv -----
`default_nettype none

package slsel_pkg;

  localparam int unsigned STORE_ENTRIES = 40;
  localparam int unsigned MAX_PER_LINE  = 10;
  localparam int unsigned STORE_BYTES   = STORE_ENTRIES * 4;

  localparam int unsigned ROW_W  = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;
  localparam int unsigned SCAN_W = $clog2(STORE_ENTRIES + 1);
  localparam int unsigned IDX_W  = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PER_LINE + 1);
  localparam int unsigned SLOT_W = 6;

  localparam int unsigned LINE_BIAS    = 16;
  localparam int unsigned SHORT_HEIGHT = 8;
  localparam int unsigned TALL_HEIGHT  = 16;

  // request kinds carried on the input tuser
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_SCAN  = 2'd2;

  typedef struct packed {
    logic [7:0] flags;
    logic [7:0] tile;
    logic [7:0] x;
    logic [7:0] y;
  } entry_t;

  typedef struct packed {
    logic              clr;
    logic              ins;
    logic [7:0]        x;
    logic [SLOT_W-1:0] slot;
  } sort_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LOAD,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_LOAD,
    ST_EMPTY
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/slsel_store.sv -----
`default_nettype none

module slsel_store (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       wr_en_i,
  input  wire logic [slsel_pkg::ROW_W-1:0] wr_row_i,
  input  wire logic [1:0]                 wr_lane_i,
  input  wire logic [7:0]                 wr_byte_i,
  input  wire logic                       rd_en_i,
  input  wire logic [slsel_pkg::ROW_W-1:0] rd_row_i,
  output slsel_pkg::entry_t               rd_entry_o
);

  logic [3:0][7:0] mem_q [slsel_pkg::STORE_ENTRIES];
  logic [3:0]      vld_q [slsel_pkg::STORE_ENTRIES];
  logic [3:0][7:0] rd_data_q;
  logic [3:0]      rd_vld_q;
  logic [3:0][7:0] masked;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_row_i][wr_lane_i] <= wr_byte_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  // per-byte written marks, unwritten bytes read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < slsel_pkg::STORE_ENTRIES; i++) begin
        vld_q[i] <= 4'b0000;
      end
      rd_vld_q <= 4'b0000;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_row_i][wr_lane_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_row_i];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      masked[j] = rd_vld_q[j] ? rd_data_q[j] : 8'h00;
    end
  end

  assign rd_entry_o = slsel_pkg::entry_t'(masked);

endmodule

`default_nettype wire

// ----- hw/rtl/slsel_sort.sv -----
`default_nettype none

module slsel_sort (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire slsel_pkg::sort_req_t        req_i,
  input  wire logic [slsel_pkg::IDX_W-1:0] rd_idx_i,
  output logic [slsel_pkg::SLOT_W-1:0]     rd_slot_o,
  output logic [slsel_pkg::CNT_W-1:0]      cnt_o
);

  logic [7:0]                  x_q    [slsel_pkg::MAX_PER_LINE];
  logic [slsel_pkg::SLOT_W-1:0] slot_q [slsel_pkg::MAX_PER_LINE];
  logic [7:0]                  x_d    [slsel_pkg::MAX_PER_LINE];
  logic [slsel_pkg::SLOT_W-1:0] slot_d [slsel_pkg::MAX_PER_LINE];
  logic [7:0]                  x_prev [slsel_pkg::MAX_PER_LINE];
  logic [slsel_pkg::SLOT_W-1:0] slot_prev [slsel_pkg::MAX_PER_LINE];
  logic [slsel_pkg::MAX_PER_LINE-1:0] gt;
  logic [slsel_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                        prev_gt;
  logic                        at_pt;

  // entries above the new x move up one place, equal x stays in front
  always_comb begin
    x_prev[0]    = 8'h00;
    slot_prev[0] = '0;
    for (int i = 1; i < slsel_pkg::MAX_PER_LINE; i++) begin
      x_prev[i]    = x_q[i-1];
      slot_prev[i] = slot_q[i-1];
    end
    for (int i = 0; i < slsel_pkg::MAX_PER_LINE; i++) begin
      gt[i] = (slsel_pkg::CNT_W'(i) < cnt_q) && (x_q[i] > req_i.x);
    end
    prev_gt = 1'b0;
    at_pt   = 1'b0;
    for (int i = 0; i < slsel_pkg::MAX_PER_LINE; i++) begin
      x_d[i]    = x_q[i];
      slot_d[i] = slot_q[i];
      at_pt = (slsel_pkg::CNT_W'(i) <= cnt_q) && ((slsel_pkg::CNT_W'(i) == cnt_q) || gt[i])
              && !prev_gt;
      if (req_i.ins) begin
        if (prev_gt) begin
          x_d[i]    = x_prev[i];
          slot_d[i] = slot_prev[i];
        end else if (at_pt) begin
          x_d[i]    = req_i.x;
          slot_d[i] = req_i.slot;
        end
      end
      prev_gt = gt[i];
    end
    if (req_i.clr) begin
      cnt_d = '0;
    end else if (req_i.ins) begin
      cnt_d = cnt_q + slsel_pkg::CNT_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < slsel_pkg::MAX_PER_LINE; i++) begin
      x_q[i]    <= x_d[i];
      slot_q[i] <= slot_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign rd_slot_o = slot_q[rd_idx_i];
  assign cnt_o     = cnt_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sprite_line_selector_core.sv -----
`default_nettype none

// sprite line selector: 40-entry sprite attribute store with a per-line scan
//
// s_axis carries requests: tuser is the kind (write byte, read byte, scan
// line), tdata the offset, the byte to write and the line number. m_axis
// carries results: tuser is found, tlast marks the final result of a request.
// a write gives no result. a read gives one result via the store read and
// output registers. a scan walks all 40 entries, one memory read per cycle,
// keeping up to 10 hits in an insertion-sorted list ordered by x; it then
// re-reads each kept entry from the store (read state, then load state), or
// gives a single result with found clear when none hit. the store has a
// single read port; one request is in work at a time, and requests are
// taken again as soon as the last result sits in the output register. when
// the receiver stalls the output register holds and the emit sequence waits.
// reset clears the byte-written marks (the store reads as all zero), the
// list count and tall_sprites; no clearing pass is needed. the user must
// write tall_sprites (cfg_we_i) between requests; the block does not check.

module sprite_line_selector_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,      // tall_sprites
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // store_offset, write_byte, line_number
  input  wire logic [1:0]  s_axis_tuser_i,   // kind
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // read_byte, entry_slot, sprite_y,
                                             // sprite_x, sprite_tile, sprite_flags
  output logic [0:0]       m_axis_tuser_o,   // found
  output logic             m_axis_tlast_o
);

  slsel_pkg::state_e state_q, state_d;

  logic tall_q;

  // request fields
  logic [1:0] in_kind;
  logic [7:0] in_off;
  logic [7:0] in_wbyte;
  logic [7:0] in_line;
  logic       in_fire;
  logic       in_range;

  // store ports
  logic                         wr_en;
  logic                         rd_en;
  logic [slsel_pkg::ROW_W-1:0]  rd_row;
  logic [slsel_pkg::ROW_W-1:0]  off_row;
  slsel_pkg::entry_t            rd_entry;

  // sorter
  slsel_pkg::sort_req_t         sort_req;
  logic [slsel_pkg::SLOT_W-1:0] sort_slot;
  logic [slsel_pkg::CNT_W-1:0]  sort_cnt;

  // sequencing registers
  logic [slsel_pkg::SCAN_W-1:0] scan_idx_q, scan_idx_d;
  logic                         pend_q, pend_d;
  logic [slsel_pkg::ROW_W-1:0]  pend_row_q, pend_row_d;
  logic [slsel_pkg::CNT_W-1:0]  emit_idx_q, emit_idx_d;
  logic [slsel_pkg::CNT_W-1:0]  emit_nxt;
  logic [1:0]                   lane_q, lane_d;
  logic                         oob_q, oob_d;
  logic [7:0]                   line_q, line_d;

  // scan hit test
  logic [8:0] target;
  logic [8:0] y_top;
  logic       hit;
  logic       scan_done;
  logic       emit_last;

  // output register
  logic                         out_free;
  logic                         out_load;
  logic                         out_vld_q;
  logic [7:0]                   out_rbyte_q, out_rbyte_d;
  logic                         out_found_q, out_found_d;
  logic [slsel_pkg::SLOT_W-1:0] out_slot_q, out_slot_d;
  slsel_pkg::entry_t            out_entry_q, out_entry_d;
  logic                         out_last_q, out_last_d;

  assign in_kind  = s_axis_tuser_i;
  assign in_off   = s_axis_tdata_i[7:0];
  assign in_wbyte = s_axis_tdata_i[15:8];
  assign in_line  = s_axis_tdata_i[23:16];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_range = {1'b0, in_off} < 9'(slsel_pkg::STORE_BYTES);
  assign off_row  = in_off[slsel_pkg::ROW_W+1:2];

  assign out_free = !out_vld_q || m_axis_tready_i;

  // y <= line + 16 < y + height, x nonzero
  assign target = {1'b0, line_q} + 9'(slsel_pkg::LINE_BIAS);
  assign y_top  = {1'b0, rd_entry.y} +
                  (tall_q ? 9'(slsel_pkg::TALL_HEIGHT) : 9'(slsel_pkg::SHORT_HEIGHT));
  assign hit    = (rd_entry.x != 8'h00) && (target >= {1'b0, rd_entry.y}) && (target < y_top);

  assign scan_done = (scan_idx_q == slsel_pkg::SCAN_W'(slsel_pkg::STORE_ENTRIES)) && pend_q;
  assign emit_nxt  = emit_idx_q + slsel_pkg::CNT_W'(1);
  assign emit_last = emit_nxt == sort_cnt;

  slsel_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_row_i   (off_row),
    .wr_lane_i  (in_off[1:0]),
    .wr_byte_i  (in_wbyte),
    .rd_en_i    (rd_en),
    .rd_row_i   (rd_row),
    .rd_entry_o (rd_entry)
  );

  slsel_sort u_sort (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (sort_req),
    .rd_idx_i  (emit_idx_q[slsel_pkg::IDX_W-1:0]),
    .rd_slot_o (sort_slot),
    .cnt_o     (sort_cnt)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      slsel_pkg::ST_IDLE: begin
        if (in_fire && (in_kind == slsel_pkg::KIND_READ)) begin
          state_d = slsel_pkg::ST_RD_LOAD;
        end else if (in_fire && (in_kind == slsel_pkg::KIND_SCAN)) begin
          state_d = slsel_pkg::ST_SCAN;
        end
      end
      slsel_pkg::ST_RD_LOAD: begin
        if (out_free) begin
          state_d = slsel_pkg::ST_IDLE;
        end
      end
      slsel_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = ((sort_cnt == '0) && !sort_req.ins) ? slsel_pkg::ST_EMPTY
                                                        : slsel_pkg::ST_EMIT_RD;
        end
      end
      slsel_pkg::ST_EMIT_RD: begin
        state_d = slsel_pkg::ST_EMIT_LOAD;
      end
      slsel_pkg::ST_EMIT_LOAD: begin
        if (out_free) begin
          state_d = emit_last ? slsel_pkg::ST_IDLE : slsel_pkg::ST_EMIT_RD;
        end
      end
      slsel_pkg::ST_EMPTY: begin
        if (out_free) begin
          state_d = slsel_pkg::ST_IDLE;
        end
      end
      default: state_d = slsel_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready_o = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    rd_row          = off_row;
    sort_req.clr    = 1'b0;
    sort_req.ins    = 1'b0;
    sort_req.x      = rd_entry.x;
    sort_req.slot   = slsel_pkg::SLOT_W'(pend_row_q);
    out_load        = 1'b0;
    out_rbyte_d     = 8'h00;
    out_found_d     = 1'b0;
    out_slot_d      = '0;
    out_entry_d     = '0;
    out_last_d      = 1'b1;
    scan_idx_d      = scan_idx_q;
    pend_d          = 1'b0;
    pend_row_d      = pend_row_q;
    emit_idx_d      = emit_idx_q;
    lane_d          = lane_q;
    oob_d           = oob_q;
    line_d          = line_q;
    unique case (state_q)
      slsel_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        wr_en = in_fire && (in_kind == slsel_pkg::KIND_WRITE) && in_range;
        rd_en = in_fire && (in_kind == slsel_pkg::KIND_READ) && in_range;
        lane_d = in_off[1:0];
        oob_d  = !in_range;
        if (in_fire && (in_kind == slsel_pkg::KIND_SCAN)) begin
          sort_req.clr = 1'b1;
          scan_idx_d   = '0;
          line_d       = in_line;
          emit_idx_d   = '0;
        end
      end
      slsel_pkg::ST_RD_LOAD: begin
        out_load    = out_free;
        out_rbyte_d = oob_q ? 8'h00 : rd_entry[lane_q*8 +: 8];
      end
      slsel_pkg::ST_SCAN: begin
        if (scan_idx_q < slsel_pkg::SCAN_W'(slsel_pkg::STORE_ENTRIES)) begin
          rd_en      = 1'b1;
          rd_row     = scan_idx_q[slsel_pkg::ROW_W-1:0];
          scan_idx_d = scan_idx_q + slsel_pkg::SCAN_W'(1);
          pend_d     = 1'b1;
          pend_row_d = scan_idx_q[slsel_pkg::ROW_W-1:0];
        end
        // the list stops growing at its limit, later hits are dropped
        sort_req.ins = pend_q && hit &&
                       (sort_cnt < slsel_pkg::CNT_W'(slsel_pkg::MAX_PER_LINE));
      end
      slsel_pkg::ST_EMIT_RD: begin
        rd_en  = 1'b1;
        rd_row = sort_slot[slsel_pkg::ROW_W-1:0];
      end
      slsel_pkg::ST_EMIT_LOAD: begin
        out_load    = out_free;
        out_found_d = 1'b1;
        out_slot_d  = sort_slot;
        out_entry_d = rd_entry;
        out_last_d  = emit_last;
        if (out_free) begin
          emit_idx_d = emit_nxt;
        end
      end
      slsel_pkg::ST_EMPTY: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= slsel_pkg::ST_IDLE;
      tall_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      pend_q     <= 1'b0;
      scan_idx_q <= '0;
      emit_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      pend_q     <= pend_d;
      scan_idx_q <= scan_idx_d;
      emit_idx_q <= emit_idx_d;
      if (cfg_we_i) begin
        tall_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_row_q <= pend_row_d;
    lane_q     <= lane_d;
    oob_q      <= oob_d;
    line_q     <= line_d;
    if (out_load) begin
      out_rbyte_q <= out_rbyte_d;
      out_found_q <= out_found_d;
      out_slot_q  <= out_slot_d;
      out_entry_q <= out_entry_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_entry_q.flags, out_entry_q.tile, out_entry_q.x,
                            out_entry_q.y, out_slot_q, out_rbyte_q};
  assign m_axis_tuser_o  = out_found_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_list_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sort_cnt <= slsel_pkg::CNT_W'(slsel_pkg::MAX_PER_LINE))
    else $error("sprite list count above limit");

  a_port_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("store write and read in the same cycle");

  a_found_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (out_slot_q < slsel_pkg::SLOT_W'(slsel_pkg::STORE_ENTRIES)))
    else $error("found result carries a slot outside the store");

  a_empty_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == slsel_pkg::ST_EMPTY) |-> (sort_cnt == '0))
    else $error("empty result with sprites kept");
`endif

endmodule

`default_nettype wire

// ----- dv/slsel_checker.sv -----
`default_nettype none

module slsel_checker
  import slsel_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  input  wire logic        s_axis_tready_i,
  input  wire logic [23:0] s_axis_tdata_i,   // store_offset, write_byte, line_number
  input  wire logic [1:0]  s_axis_tuser_i,   // kind
  input  wire logic        m_axis_tvalid_i,
  input  wire logic        m_axis_tready_i,
  input  wire logic [47:0] m_axis_tdata_i,   // read_byte, entry_slot, sprite_y,
                                             // sprite_x, sprite_tile, sprite_flags
  input  wire logic [0:0]  m_axis_tuser_i,   // found
  input  wire logic        m_axis_tlast_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic              found;
    logic [SLOT_W-1:0] slot;
    entry_t            sprite;
    logic              last;
  } line_result_t;

  logic [7:0]   sprite_mem [STORE_BYTES];
  logic         tall_q;
  line_result_t result_q [$];
  int           fail_count;
  int           pending;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic entry_t entry_at(input int unsigned slot);
    return {sprite_mem[slot*4+3], sprite_mem[slot*4+2], sprite_mem[slot*4+1],
            sprite_mem[slot*4]};
  endfunction

  // walk the store in order, keep hits sorted by x with ties in store order
  task automatic predict_scan(input logic [7:0] scan_line);
    int unsigned       span;
    int unsigned       target;
    int unsigned       hits;
    int unsigned       pos;
    int unsigned       e;
    logic [SLOT_W-1:0] order [MAX_PER_LINE];
    entry_t            ent;
    line_result_t      r;
    span   = tall_q ? TALL_HEIGHT : SHORT_HEIGHT;
    target = scan_line + LINE_BIAS;
    hits   = 0;
    for (e = 0; e < STORE_ENTRIES && hits < MAX_PER_LINE; e++) begin
      ent = entry_at(e);
      if (ent.x != 8'd0 && ent.y <= target && target < ent.y + span) begin
        pos = hits;
        while (pos > 0 && entry_at(order[pos-1]).x > ent.x) begin
          order[pos] = order[pos-1];
          pos--;
        end
        order[pos] = SLOT_W'(e);
        hits++;
      end
    end
    if (hits == 0) begin
      r      = '0;
      r.last = 1'b1;
      result_q.push_back(r);
    end else begin
      for (pos = 0; pos < hits; pos++) begin
        r           = '0;
        r.found     = 1'b1;
        r.slot      = order[pos];
        r.sprite    = entry_at(order[pos]);
        r.last      = (pos + 1 == hits);
        result_q.push_back(r);
      end
    end
  endtask

  task automatic predict_request(input logic [1:0] kind, input logic [23:0] data);
    logic [7:0]   off;
    line_result_t r;
    off = data[7:0];
    case (kind)
      KIND_WRITE: begin
        if (off < STORE_BYTES) sprite_mem[off] = data[15:8];
      end
      KIND_READ: begin
        r           = '0;
        r.read_byte = (off < STORE_BYTES) ? sprite_mem[off] : 8'd0;
        r.last      = 1'b1;
        result_q.push_back(r);
      end
      KIND_SCAN: predict_scan(data[23:16]);
      default: ;  // unused kind gives nothing
    endcase
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_result_t want;
    if (!rst_ni) begin
      foreach (sprite_mem[k]) sprite_mem[k] = 8'd0;
      tall_q = 1'b0;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we_i) tall_q = cfg_wdata_i;
      // results first, so a request taken at the same edge queues behind them
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (result_q.size() == 0) begin
          $error("result item with none expected: tdata 0x%0h", m_axis_tdata_i);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          compare_field("read_byte",    want.read_byte,    m_axis_tdata_i[7:0]);
          compare_field("entry_slot",   want.slot,         m_axis_tdata_i[13:8]);
          compare_field("sprite_y",     want.sprite.y,     m_axis_tdata_i[21:14]);
          compare_field("sprite_x",     want.sprite.x,     m_axis_tdata_i[29:22]);
          compare_field("sprite_tile",  want.sprite.tile,  m_axis_tdata_i[37:30]);
          compare_field("sprite_flags", want.sprite.flags, m_axis_tdata_i[45:38]);
          compare_field("tdata_pad",    0,                 m_axis_tdata_i[47:46]);
          compare_field("found",        want.found,        m_axis_tuser_i[0]);
          compare_field("last",         want.last,         m_axis_tlast_i);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) predict_request(s_axis_tuser_i, s_axis_tdata_i);
    end
    pending = result_q.size();
  end

endmodule

`default_nettype wire

// ----- dv/tb_sprite_line_selector_core.sv -----
`default_nettype none

module tb_sprite_line_selector_core;
  timeunit 1ns;
  timeprecision 1ps;
  import slsel_pkg::*;

  // kind value the block ignores
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam int unsigned ITEM_TARGET = 430;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 100;   // past a full scan and its emit
  localparam int unsigned SETTLE_WAIT = 10;    // lets a trailing write finish

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = KIND_WRITE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  int          fail_count;
  int          pending;

  // sender pacing
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          no_idle = 1'b0;
  logic        tall_mode = 1'b0;

  sprite_line_selector_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  slsel_checker sprite_scoreboard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // hard stop if the block hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: stall pattern that switches between none, light and heavy
  initial begin : rx_pattern
    int unsigned stall_left;
    int unsigned mode;
    int unsigned span;
    stall_left = 0;
    mode       = 0;
    span       = 0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 200);
      end
      span--;
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        case (mode)
          1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
          2: if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(4, 20);
          default: ;
        endcase
      end
    end
  end

  // called at a falling edge, returns at a falling edge with the item taken;
  // valid stays up so a back-to-back item follows without a dip
  task automatic send_req(input logic [1:0] kind, input logic [7:0] off,
                          input logic [7:0] wb, input logic [7:0] scan_line);
    if (burst_left == 0) begin
      if (!no_idle) begin
        s_tvalid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {scan_line, wb, off};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    // ignored requests do not count toward the item budget
    if (!(kind == KIND_NONE || (kind == KIND_WRITE && off >= STORE_BYTES))) items_sent++;
  endtask

  // drop valid, let all expected items drain, then let a trailing write finish
  task automatic settle();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_WAIT) @(negedge clk_i);
  endtask

  task automatic set_tall(input logic value);
    settle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    tall_mode = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // fill a few entries around one line, maybe read a byte, then scan the line and maybe a nearby one
  task automatic line_episode();
    logic [7:0]  scan_line;
    logic [7:0]  y;
    logic [7:0]  x;
    int unsigned span;
    int unsigned slot;
    scan_line = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 153))
                                            : 8'($urandom_range(154, 255));
    span = tall_mode ? TALL_HEIGHT : SHORT_HEIGHT;
    repeat ($urandom_range(1, 12)) begin
      slot = $urandom_range(0, STORE_ENTRIES - 1);
      // mostly covering the line, a few ending just short of it
      y = 8'(scan_line + LINE_BIAS - $urandom_range(0, span + 1));
      case ($urandom_range(0, 9))
        0:       x = 8'd0;
        1, 2, 3: x = 8'(8 + $urandom_range(0, 2));   // ties
        default: x = 8'($urandom_range(1, 255));
      endcase
      send_req(KIND_WRITE, 8'(slot * 4),     y, 8'($urandom));
      send_req(KIND_WRITE, 8'(slot * 4 + 1), x, 8'($urandom));
      if ($urandom_range(0, 1) == 0) begin
        send_req(KIND_WRITE, 8'(slot * 4 + 2), 8'($urandom), 8'($urandom));
        send_req(KIND_WRITE, 8'(slot * 4 + 3), 8'($urandom), 8'($urandom));
      end
    end
    if ($urandom_range(0, 2) == 0)
      send_req(KIND_READ, 8'($urandom_range(0, STORE_BYTES - 1)), 8'($urandom), 8'($urandom));
    send_req(KIND_SCAN, 8'($urandom), 8'($urandom), scan_line);
    if ($urandom_range(0, 2) == 0)
      send_req(KIND_SCAN, 8'($urandom), 8'($urandom), 8'(scan_line + $urandom_range(0, 4) - 2));
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty store, out-of-range offsets, extremes, ties, x zero
    set_tall(1'b0);
    send_req(KIND_READ,  8'd0,   8'h00, 8'h00);
    send_req(KIND_WRITE, 8'd255, 8'hAA, 8'hFF);   // beyond the store, dropped
    send_req(KIND_READ,  8'd255, 8'h00, 8'h00);
    send_req(KIND_WRITE, 8'd160, 8'h55, 8'h00);
    send_req(KIND_READ,  8'd160, 8'h00, 8'h00);
    send_req(KIND_WRITE, 8'd159, 8'hFF, 8'h00);   // last entry flags
    send_req(KIND_READ,  8'd159, 8'h00, 8'h00);
    send_req(KIND_WRITE, 8'd0,   8'd16, 8'h00);   // entry 0 covers line 0
    send_req(KIND_WRITE, 8'd1,   8'd255, 8'h00);
    send_req(KIND_WRITE, 8'd4,   8'd16, 8'h00);   // entries 1 and 2 tie on x
    send_req(KIND_WRITE, 8'd5,   8'd8,  8'h00);
    send_req(KIND_WRITE, 8'd8,   8'd17, 8'h00);
    send_req(KIND_WRITE, 8'd9,   8'd8,  8'h00);
    send_req(KIND_WRITE, 8'd12,  8'd16, 8'h00);   // entry 3 keeps x zero
    send_req(KIND_SCAN,  8'h00,  8'h00, 8'd0);
    send_req(KIND_NONE,  8'h00,  8'h00, 8'd0);    // ignored kind
    send_req(KIND_SCAN,  8'h00,  8'h00, 8'd153);  // empty scan
    send_req(KIND_SCAN,  8'hFF,  8'hFF, 8'd255);  // line past the display
    send_req(KIND_WRITE, 8'd2,   8'h00, 8'h00);
    send_req(KIND_READ,  8'd2,   8'h00, 8'h00);
    set_tall(1'b1);
    send_req(KIND_SCAN,  8'h00,  8'h00, 8'd0);
    send_req(KIND_SCAN,  8'h00,  8'h00, 8'd7);
    send_req(KIND_SCAN,  8'h00,  8'h00, 8'd16);

    // random phases, each under its own height setting and pacing
    while (items_sent < ITEM_TARGET) begin
      set_tall(1'($urandom_range(0, 1)));
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + $urandom_range(60, 120);
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        if ($urandom_range(0, 3) != 0) begin
          line_episode();
        end else begin
          repeat ($urandom_range(1, 6))
            send_req(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end

    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
